// ===== src/efs_pkg.sv =====
// ----------------------------------------------------------------------------
// efs_pkg
// shared types, constants and helpers for the ethernet frame statistics block
// ----------------------------------------------------------------------------
package efs_pkg;

  localparam int unsigned CounterBitsDef   = 48;
  localparam int unsigned MaxFrameBytesDef = 16383;
  localparam int unsigned NumCounters      = 23;
  localparam int unsigned SizeBits         = 16;
  localparam int unsigned IdxBits          = 5;
  localparam int unsigned OutBits          = 48;

  localparam logic [4:0] CntFrames   = 5'd0;
  localparam logic [4:0] CntBytes    = 5'd1;
  localparam logic [4:0] CntLe64     = 5'd2;
  localparam logic [4:0] CntLe255    = 5'd3;
  localparam logic [4:0] CntLe511    = 5'd4;
  localparam logic [4:0] CntLe1023   = 5'd5;
  localparam logic [4:0] CntLe1518   = 5'd6;
  localparam logic [4:0] CntOver     = 5'd7;
  localparam logic [4:0] CntIpv4     = 5'd8;
  localparam logic [4:0] CntNonIpv4  = 5'd9;
  localparam logic [4:0] CntTcp      = 5'd10;
  localparam logic [4:0] CntUdp      = 5'd11;
  localparam logic [4:0] CntIcmp     = 5'd12;
  localparam logic [4:0] CntOtherL4  = 5'd13;
  localparam logic [4:0] CntSyn      = 5'd14;
  localparam logic [4:0] CntSynAck   = 5'd15;
  localparam logic [4:0] CntAck      = 5'd16;
  localparam logic [4:0] CntFinAck   = 5'd17;
  localparam logic [4:0] CntRst      = 5'd18;
  localparam logic [4:0] CntRstAck   = 5'd19;
  localparam logic [4:0] CntOtherFlg = 5'd20;
  localparam logic [4:0] CntL3Good   = 5'd21;
  localparam logic [4:0] CntL4Good   = 5'd22;

  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;
  localparam logic [7:0]  ProtoTcp      = 8'd6;
  localparam logic [7:0]  ProtoUdp      = 8'd17;
  localparam logic [7:0]  ProtoIcmp     = 8'd1;
  localparam logic [7:0]  FlagSyn       = 8'h02;
  localparam logic [7:0]  FlagSynAck    = 8'h12;
  localparam logic [7:0]  FlagAck       = 8'h10;
  localparam logic [7:0]  FlagFinAck    = 8'h11;
  localparam logic [7:0]  FlagRst       = 8'h04;
  localparam logic [7:0]  FlagRstAck    = 8'h14;
  localparam logic [15:0] SumGood       = 16'hFFFF;

  typedef logic [NumCounters-1:0] mask_t;

  typedef struct packed {
    logic                is_read;
    logic [IdxBits-1:0]  idx;
    logic [SizeBits-1:0] size;
    mask_t               mask;
  } entry_t;

  typedef struct packed {
    logic                is_read;
    logic [IdxBits-1:0]  idx;
    logic [SizeBits-1:0] size;
    logic [15:0]         ether_type;
    logic [3:0]          hdr_words;
    logic [15:0]         total_len;
    logic [7:0]          proto;
    logic [7:0]          flags;
    logic [15:0]         l3_sum;
    logic [15:0]         l4_sum;
  } frame_t;

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] t;
    t = {1'b0, a} + {1'b0, b};
    return t[16] ? (t[15:0] + 16'd1) : t[15:0];
  endfunction

endpackage

// ===== src/ethernet_frame_statistics.sv =====
// a read transfer returns its counter via the parser stage register, the queue and the result register
// throughput: one transfer per cycle, bytes and reads alike, while the queue is not full; set by the byte parser
// counters update once a frame's last byte has passed the parser stage register and the queue; later reads see them
// reset: asynchronous, active low; clears all counters and frame state at once
// ----------------------------------------------------------------------------
// ethernet_frame_statistics
// rmon style frame statistics over a byte stream with counter readback
// ----------------------------------------------------------------------------
module ethernet_frame_statistics #(
  parameter int unsigned COUNTER_BITS    = efs_pkg::CounterBitsDef,
  parameter int unsigned MAX_FRAME_BYTES = efs_pkg::MaxFrameBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte[7:0], counter_index[12:8], zero
  input  logic        s_axis_tuser,   // opcode
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // counter_value
);

  logic            q_push, q_full, q_pop, q_empty;
  efs_pkg::entry_t e_in, e_out;

  efs_parser #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_parser (
    .clk_i, .rst_ni,
    .valid_i(s_axis_tvalid), .ready_o(s_axis_tready),
    .opcode_i(s_axis_tuser), .data_byte_i(s_axis_tdata[7:0]),
    .last_byte_i(s_axis_tlast), .counter_index_i(s_axis_tdata[12:8]),
    .push_o(q_push), .full_i(q_full), .entry_o(e_in)
  );

  efs_queue u_queue (
    .clk_i, .rst_ni,
    .push_i(q_push), .entry_i(e_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .entry_o(e_out)
  );

  efs_counters #(.COUNTER_BITS(COUNTER_BITS)) u_counters (
    .clk_i, .rst_ni,
    .empty_i(q_empty), .entry_i(e_out), .pop_o(q_pop),
    .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .data_o(m_axis_tdata)
  );

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_pop && q_empty)) else $error("queue underflow");
  a_result_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(q_pop && e_out.is_read))
    else $error("result without read");

endmodule

// ===== src/efs_parser.sv =====
// ----------------------------------------------------------------------------
// efs_parser
// front part: header capture, running checksums and frame classification
// ----------------------------------------------------------------------------
module efs_parser #(
  parameter int unsigned MAX_FRAME_BYTES = efs_pkg::MaxFrameBytesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic                       opcode_i,
  input  logic [7:0]                 data_byte_i,
  input  logic                       last_byte_i,
  input  logic [efs_pkg::IdxBits-1:0] counter_index_i,
  output logic                       push_o,
  input  logic                       full_i,
  output efs_pkg::entry_t            entry_o
);

  localparam int unsigned OW = $clog2(MAX_FRAME_BYTES + 1);

  logic [OW-1:0] off_q, off_d;
  logic [15:0]   et_q, et_d, tl_q, tl_d, l3_q, l3_d, l4_q, l4_d;
  logic [3:0]    hw_q, hw_d;
  logic [7:0]    pr_q, pr_d, fl_q, fl_d, hold_q, hold_d;
  logic          s2_valid_q, s2_valid_d;
  efs_pkg::frame_t s2_q, s2_d;

  logic          acc, take, emit;
  logic [16:0]   off17, ls, le;
  logic          ok_ihl;
  logic [15:0]   word;
  logic [OW-1:0] size_now;

  assign acc     = valid_i & ready_o;
  assign ready_o = !s2_valid_q || !full_i;
  assign push_o  = s2_valid_q && !full_i;

  assign off17  = 17'(off_q);
  assign ls     = 17'd14 + 17'({hw_q, 2'b00});
  assign le     = 17'd14 + 17'(tl_q);
  assign ok_ihl = hw_q >= 4'd5;
  assign word   = {hold_q, data_byte_i};
  assign take   = off_q < OW'(MAX_FRAME_BYTES);
  assign size_now = take ? off_q + OW'(1) : off_q;

  always_comb begin
    off_d = off_q; et_d = et_q; tl_d = tl_q; l3_d = l3_q; l4_d = l4_q;
    hw_d = hw_q; pr_d = pr_q; fl_d = fl_q; hold_d = hold_q;
    if (acc && !opcode_i && take) begin
      off_d = size_now;
      case (off17)
        17'd12: et_d = {data_byte_i, 8'h00};
        17'd13: et_d = {et_q[15:8], data_byte_i};
        17'd14: hw_d = data_byte_i[3:0];
        17'd16: tl_d = {data_byte_i, 8'h00};
        17'd17: tl_d = {tl_q[15:8], data_byte_i};
        17'd23: pr_d = data_byte_i;
        default: ;
      endcase
      if (off17 >= 17'd14) begin
        if (ok_ihl && off17 == ls + 17'd13) fl_d = data_byte_i;
        if (!off17[0]) begin
          hold_d = data_byte_i;
          if (ok_ihl && off17 >= ls && off17 + 17'd1 == le)
            l4_d = efs_pkg::ones_add(l4_q, {data_byte_i, 8'h00});
        end else begin
          if (ok_ihl && off17 < ls) l3_d = efs_pkg::ones_add(l3_q, word);
          if (off17 >= 17'd26 && off17 <= 17'd33) l4_d = efs_pkg::ones_add(l4_q, word);
          if (ok_ihl && off17 >= ls && off17 < le) l4_d = efs_pkg::ones_add(l4_q, word);
        end
      end
    end
  end

  always_comb begin
    s2_d            = s2_q;
    emit            = 1'b0;
    s2_d.is_read    = opcode_i;
    s2_d.idx        = counter_index_i;
    s2_d.size       = efs_pkg::SizeBits'(size_now);
    s2_d.ether_type = et_d;
    s2_d.hdr_words  = hw_d;
    s2_d.total_len  = tl_d;
    s2_d.proto      = pr_d;
    s2_d.flags      = fl_d;
    s2_d.l3_sum     = l3_d;
    s2_d.l4_sum     = l4_d;
    if (acc) emit = opcode_i || (last_byte_i && (size_now >= OW'(14)));
    s2_valid_d = emit ? 1'b1 : (push_o ? 1'b0 : s2_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q <= '0; et_q <= '0; tl_q <= '0; l3_q <= '0; l4_q <= '0;
      hw_q <= '0; pr_q <= '0; fl_q <= '0; hold_q <= '0; s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s2_valid_d;
      if (acc && !opcode_i && last_byte_i) begin
        off_q <= '0; et_q <= '0; tl_q <= '0; l3_q <= '0; l4_q <= '0;
        hw_q <= '0; pr_q <= '0; fl_q <= '0; hold_q <= '0;
      end else begin
        off_q <= off_d; et_q <= et_d; tl_q <= tl_d; l3_q <= l3_d; l4_q <= l4_d;
        hw_q <= hw_d; pr_q <= pr_d; fl_q <= fl_d; hold_q <= hold_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) s2_q <= s2_d;
  end

  // classification of the captured frame
  logic [15:0] ip_len, hlen, l4s;
  efs_pkg::mask_t m;

  always_comb begin
    m      = '0;
    ip_len = s2_q.size - 16'd14;
    hlen   = 16'({s2_q.hdr_words, 2'b00});
    l4s    = efs_pkg::ones_add(efs_pkg::ones_add(s2_q.l4_sum, {8'h00, s2_q.proto}),
                               s2_q.total_len - hlen);
    m[efs_pkg::CntFrames] = 1'b1;
    m[efs_pkg::CntBytes]  = 1'b1;
    if (s2_q.size <= 16'd64)        m[efs_pkg::CntLe64]   = 1'b1;
    else if (s2_q.size <= 16'd255)  m[efs_pkg::CntLe255]  = 1'b1;
    else if (s2_q.size <= 16'd511)  m[efs_pkg::CntLe511]  = 1'b1;
    else if (s2_q.size <= 16'd1023) m[efs_pkg::CntLe1023] = 1'b1;
    else if (s2_q.size <= 16'd1518) m[efs_pkg::CntLe1518] = 1'b1;
    else                            m[efs_pkg::CntOver]   = 1'b1;
    if (s2_q.ether_type != efs_pkg::EtherTypeIpv4) begin
      m[efs_pkg::CntNonIpv4] = 1'b1;
    end else if (ip_len >= 16'd20) begin
      m[efs_pkg::CntIpv4] = 1'b1;
      if (s2_q.hdr_words >= 4'd5) begin
        if (ip_len >= hlen && s2_q.l3_sum == efs_pkg::SumGood) m[efs_pkg::CntL3Good] = 1'b1;
        if (ip_len >= s2_q.total_len && s2_q.total_len >= hlen && l4s == efs_pkg::SumGood)
          m[efs_pkg::CntL4Good] = 1'b1;
        if (ip_len >= hlen) begin
          if (s2_q.proto == efs_pkg::ProtoTcp) begin
            if (ip_len - hlen >= 16'd20) begin
              m[efs_pkg::CntTcp] = 1'b1;
              case (s2_q.flags)
                efs_pkg::FlagSyn:    m[efs_pkg::CntSyn]      = 1'b1;
                efs_pkg::FlagSynAck: m[efs_pkg::CntSynAck]   = 1'b1;
                efs_pkg::FlagAck:    m[efs_pkg::CntAck]      = 1'b1;
                efs_pkg::FlagFinAck: m[efs_pkg::CntFinAck]   = 1'b1;
                efs_pkg::FlagRst:    m[efs_pkg::CntRst]      = 1'b1;
                efs_pkg::FlagRstAck: m[efs_pkg::CntRstAck]   = 1'b1;
                default:             m[efs_pkg::CntOtherFlg] = 1'b1;
              endcase
            end
          end else if (s2_q.proto == efs_pkg::ProtoUdp) begin
            m[efs_pkg::CntUdp] = 1'b1;
          end else if (s2_q.proto == efs_pkg::ProtoIcmp) begin
            m[efs_pkg::CntIcmp] = 1'b1;
          end else begin
            m[efs_pkg::CntOtherL4] = 1'b1;
          end
        end
      end
    end
    entry_o.is_read = s2_q.is_read;
    entry_o.idx     = s2_q.idx;
    entry_o.size    = s2_q.size;
    entry_o.mask    = m;
  end

endmodule

// ===== src/efs_queue.sv =====
// ----------------------------------------------------------------------------
// efs_queue
// two-entry queue between the parser and the counter bank
// ----------------------------------------------------------------------------
module efs_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  efs_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output efs_pkg::entry_t entry_o
);

  efs_pkg::entry_t mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign entry_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= 1'b0; rd_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

// ===== src/efs_counters.sv =====
// ----------------------------------------------------------------------------
// efs_counters
// back part: statistics counter bank and read result register
// ----------------------------------------------------------------------------
module efs_counters #(
  parameter int unsigned COUNTER_BITS = efs_pkg::CounterBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  efs_pkg::entry_t             entry_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [efs_pkg::OutBits-1:0] data_o
);

  logic [COUNTER_BITS-1:0] cnt_q [efs_pkg::NumCounters];
  logic                    out_v_q;
  logic [efs_pkg::OutBits-1:0] out_q;
  logic [63:0]             rd_ext;

  assign pop_o   = !empty_i && (!entry_i.is_read || !out_v_q || ready_i);
  assign valid_o = out_v_q;
  assign data_o  = out_q;
  assign rd_ext  = (entry_i.idx < efs_pkg::IdxBits'(efs_pkg::NumCounters))
                   ? 64'(cnt_q[entry_i.idx]) : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      for (int i = 0; i < efs_pkg::NumCounters; i++) cnt_q[i] <= '0;
    end else begin
      if (pop_o && entry_i.is_read) out_v_q <= 1'b1;
      else if (ready_i)             out_v_q <= 1'b0;
      if (pop_o && !entry_i.is_read) begin
        for (int i = 0; i < efs_pkg::NumCounters; i++) begin
          if (entry_i.mask[i])
            cnt_q[i] <= cnt_q[i] + ((i == int'(efs_pkg::CntBytes))
                                    ? COUNTER_BITS'(entry_i.size) : COUNTER_BITS'(1));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && entry_i.is_read) out_q <= rd_ext[efs_pkg::OutBits-1:0];
  end

endmodule
